// ===== rtl/rbs_pkg.sv =====
// Shared types, constants and helper functions of the receive band selector.
// No dependencies; every other file of the block imports this package.
package rbs_pkg;

    // Range table geometry
    localparam int RANGE_ENTRIES = 16;
    localparam int PATTERN_BITS  = 8;
    localparam int ENTRY_IDX_W   = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int IDX_EXT_W     = (ENTRY_IDX_W > 4) ? ENTRY_IDX_W : 4;

    // Constant divider: one reciprocal multiply, x * ceil(2^n / d) >> n
    localparam int          DIV_STEPS = 1;
    localparam logic [31:0] RECIP_3    = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_5    = 32'hCCCC_CCCD;
    localparam int          RECIP_3_SH = 33;
    localparam int          RECIP_5_SH = 34;

    // One sequencer pass covers the table scan and the division
    localparam int SCAN_STEPS = (RANGE_ENTRIES > DIV_STEPS) ? RANGE_ENTRIES : DIV_STEPS;
    localparam int CNT_W      = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;

    // Prescaler thresholds, 11.21: 0.8, 3.2 and 10.0 truncated
    localparam logic [31:0] THR_64 = 32'd1677721;
    localparam logic [31:0] THR_16 = 32'd6710886;
    localparam logic [31:0] THR_4  = 32'd20971520;

    localparam logic [31:0] WIDTH_NONE = 32'hFFFF_FFFF;

    // Trip point patterns
    localparam logic [7:0] PAT_BELOW_LOW  = 8'(1 << 1);
    localparam logic [7:0] PAT_BELOW_MID  = 8'(1 << 2);
    localparam logic [7:0] PAT_BELOW_HIGH = 8'(1 << 0);
    localparam logic [7:0] PAT_ABOVE_HIGH = 8'(1 << 3);

    // Configuration register indexes
    localparam logic [2:0] REG_PRESELECT_MODE = 3'd0;
    localparam logic [2:0] REG_TRIP_LOW       = 3'd1;
    localparam logic [2:0] REG_TRIP_MID       = 3'd2;
    localparam logic [2:0] REG_TRIP_HIGH      = 3'd3;
    localparam logic [2:0] REG_THIRD_LIMIT    = 3'd4;
    localparam logic [2:0] REG_FIFTH_LIMIT    = 3'd5;
    localparam logic [2:0] REG_SWAP_IQ        = 3'd6;
    localparam logic [2:0] REG_LOW_POWER      = 3'd7;

    localparam logic [1:0] MODE_TRIP = 2'd0;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_BY_3,
        DIV_BY_5
    } div_mode_t;

    typedef struct packed {
        logic                    en;
        logic [ENTRY_IDX_W-1:0]  idx;
        logic [31:0]             lo;
        logic [31:0]             hi;
        logic [PATTERN_BITS-1:0] pat;
    } tbl_wr_t;

    typedef struct packed {
        logic                   clear;
        logic                   step;
        logic [ENTRY_IDX_W-1:0] idx;
    } scan_ctrl_t;

    typedef struct packed {
        logic      load;
        logic      step;
        div_mode_t mode;
    } div_ctrl_t;

    // Prescaler shift: ratio 64, 16, 4 or 1 as a power of two
    function automatic logic [2:0] ratio_shift(input logic [31:0] f);
        logic [2:0] sh;
        if (f < THR_64)
            sh = 3'd6;
        else if (f < THR_16)
            sh = 3'd4;
        else if (f < THR_4)
            sh = 3'd2;
        else
            sh = 3'd0;
        return sh;
    endfunction

endpackage

// ===== rtl/rbs_range_table.sv =====
// Preselector range table with a one-entry-per-cycle narrowest-range search.
// Depends on rbs_pkg.
module rbs_range_table
    import rbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tbl_wr_t                 wr,
    input  scan_ctrl_t              scan,
    input  logic [31:0]             freq,
    output logic [PATTERN_BITS-1:0] best_pattern
);

    logic [31:0]             lo_mem  [RANGE_ENTRIES];
    logic [31:0]             hi_mem  [RANGE_ENTRIES];
    logic [PATTERN_BITS-1:0] pat_mem [RANGE_ENTRIES];
    logic [RANGE_ENTRIES-1:0] valid_reg;

    logic [31:0]             best_reg, best_next;
    logic [PATTERN_BITS-1:0] pat_reg, pat_next;

    logic [31:0]             rd_lo, rd_hi, rd_width;
    logic [PATTERN_BITS-1:0] rd_pat;
    logic                    hit;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            lo_mem[wr.idx]  <= wr.lo;
            hi_mem[wr.idx]  <= wr.hi;
            pat_mem[wr.idx] <= wr.pat;
        end
    end

    // Entries never written read as zero, as after a cleared table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr.en)
            valid_reg[wr.idx] <= 1'b1;
    end

    always_comb
    begin
        rd_lo    = valid_reg[scan.idx] ? lo_mem[scan.idx]  : '0;
        rd_hi    = valid_reg[scan.idx] ? hi_mem[scan.idx]  : '0;
        rd_pat   = valid_reg[scan.idx] ? pat_mem[scan.idx] : '0;
        rd_width = rd_hi - rd_lo;
        hit      = (freq >= rd_lo) && (freq <= rd_hi) && (rd_width < best_reg);

        best_next = best_reg;
        pat_next  = pat_reg;
        if (scan.clear)
        begin
            best_next = WIDTH_NONE;
            pat_next  = '0;
        end
        else if (scan.step && hit)
        begin
            best_next = rd_width;
            pat_next  = rd_pat;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        pat_reg  <= pat_next;
    end

    assign best_pattern = pat_reg;

endmodule

// ===== rtl/rbs_const_div.sv =====
// Divider by 3 or 5 through one registered reciprocal multiply, or pass-through.
// Depends on rbs_pkg.
module rbs_const_div
    import rbs_pkg::*;
(
    input  logic        clk,
    input  div_ctrl_t   ctrl,
    input  logic [31:0] dividend,
    output logic [31:0] quotient
);

    div_mode_t   mode_reg, mode_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] quot_reg, quot_next;

    logic [31:0] magic;
    logic [63:0] product;

    always_comb
    begin
        magic     = (mode_reg == DIV_BY_5) ? RECIP_5 : RECIP_3;
        product   = 64'(num_reg) * 64'(magic);
        mode_next = mode_reg;
        num_next  = num_reg;
        quot_next = quot_reg;

        if (ctrl.load)
        begin
            mode_next = ctrl.mode;
            num_next  = dividend;
            quot_next = (ctrl.mode == DIV_NONE) ? dividend : '0;
        end
        else if (ctrl.step && (mode_reg != DIV_NONE))
        begin
            // Drop the fraction bits of the scaled product
            if (mode_reg == DIV_BY_5)
                quot_next = 32'(product >> RECIP_5_SH);
            else
                quot_next = 32'(product >> RECIP_3_SH);
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    assign quotient = quot_reg;

endmodule

// ===== rtl/rx_band_selector.sv =====
// Receive band selector: a tune transaction (cmd 0) is accepted when start is high and busy is
// low; busy then stays high while a sequencer steps the range table scan (one entry a cycle)
// and, in its first cycle, the divide-by-3/5 reciprocal multiply, and the result is on the
// output ports for exactly one cycle with done high, in the first cycle after busy falls. A
// table write transaction (cmd 1) leaves busy low and gives no result. The receiver cannot
// stall: sample the outputs whenever done is high. The table reads as zero after reset; no
// clearing pass is needed. Write configuration only while idle.
// Depends on rbs_pkg, rbs_range_table and rbs_const_div.
module rx_band_selector
    import rbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        cmd,
    input  logic [31:0] tune_freq,
    input  logic [3:0]  entry_index,
    input  logic [31:0] entry_low,
    input  logic [31:0] entry_high,
    input  logic [7:0]  entry_pattern,
    output logic [7:0]  filter_pattern,
    output logic [6:0]  prescale_ratio,
    output logic        iq_swap,
    output logic [31:0] vco_freq
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] freq_reg, freq_next;

    logic [1:0]  mode_reg;
    logic [15:0] trip_low_reg, trip_mid_reg, trip_high_reg;
    logic [31:0] third_reg, fifth_reg;
    logic        swap_dflt_reg, low_power_reg;

    logic        done_reg, done_next;
    logic [7:0]  pattern_reg, pattern_next;
    logic [6:0]  ratio_reg, ratio_next;
    logic        swap_reg, swap_next;
    logic [31:0] vco_reg, vco_next;

    logic                    accept;
    logic [IDX_EXT_W-1:0]    idx_ext;
    tbl_wr_t                 tbl_wr;
    scan_ctrl_t              scan;
    div_ctrl_t               div_ctrl;
    logic [PATTERN_BITS-1:0] scan_pattern;
    logic [31:0]             quotient;
    logic [31:0]             vco_raw;
    logic [15:0]             freq_top;
    logic [7:0]              trip_pattern;

    assign accept  = start && (state_reg == ST_IDLE);
    assign idx_ext = IDX_EXT_W'(entry_index);

    always_comb
    begin
        tbl_wr.en  = accept && cmd && (32'(entry_index) < RANGE_ENTRIES);
        tbl_wr.idx = idx_ext[ENTRY_IDX_W-1:0];
        tbl_wr.lo  = entry_low;
        tbl_wr.hi  = entry_high;
        tbl_wr.pat = PATTERN_BITS'(entry_pattern);
    end

    always_comb
    begin
        scan.clear = accept;
        scan.step  = (state_reg == ST_RUN) && (32'(cnt_reg) < RANGE_ENTRIES);
        scan.idx   = ENTRY_IDX_W'(cnt_reg);

        vco_raw = tune_freq << ratio_shift(tune_freq);
        div_ctrl.load = accept;
        div_ctrl.step = (state_reg == ST_RUN) && (32'(cnt_reg) < DIV_STEPS);
        if (tune_freq >= fifth_reg)
            div_ctrl.mode = DIV_BY_5;
        else if (tune_freq >= third_reg)
            div_ctrl.mode = DIV_BY_3;
        else
            div_ctrl.mode = DIV_NONE;
    end

    rbs_range_table u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (tbl_wr),
        .scan         (scan),
        .freq         (freq_reg),
        .best_pattern (scan_pattern)
    );

    rbs_const_div u_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (vco_raw),
        .quotient (quotient)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            trip_low_reg  <= '0;
            trip_mid_reg  <= '0;
            trip_high_reg <= '0;
            third_reg     <= '1;
            fifth_reg     <= '1;
            swap_dflt_reg <= 1'b0;
            low_power_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PRESELECT_MODE: mode_reg      <= cfg_wdata[1:0];
                REG_TRIP_LOW:       trip_low_reg  <= cfg_wdata[15:0];
                REG_TRIP_MID:       trip_mid_reg  <= cfg_wdata[15:0];
                REG_TRIP_HIGH:      trip_high_reg <= cfg_wdata[15:0];
                REG_THIRD_LIMIT:    third_reg     <= cfg_wdata;
                REG_FIFTH_LIMIT:    fifth_reg     <= cfg_wdata;
                REG_SWAP_IQ:        swap_dflt_reg <= cfg_wdata[0];
                REG_LOW_POWER:      low_power_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // Trip point pattern from the 11.5 view of the frequency
    always_comb
    begin
        freq_top = freq_reg[31:16];
        if (freq_top < trip_low_reg)
            trip_pattern = PAT_BELOW_LOW;
        else if (freq_top < trip_mid_reg)
            trip_pattern = PAT_BELOW_MID;
        else if (freq_top < trip_high_reg)
            trip_pattern = PAT_BELOW_HIGH;
        else
            trip_pattern = PAT_ABOVE_HIGH;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        freq_next    = freq_reg;
        done_next    = 1'b0;
        pattern_next = pattern_reg;
        ratio_next   = ratio_reg;
        swap_next    = swap_reg;
        vco_next     = vco_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !cmd)
                begin
                    freq_next  = tune_freq;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SCAN_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Assemble the result; it goes out with done on the next cycle
                if (low_power_reg)
                    pattern_next = '0;
                else if (mode_reg == MODE_TRIP)
                    pattern_next = 8'(trip_pattern & 8'((1 << PATTERN_BITS) - 1));
                else
                    pattern_next = 8'(scan_pattern);
                ratio_next = 7'(7'd1 << ratio_shift(freq_reg));
                swap_next  = swap_dflt_reg ^
                             ((freq_reg >= third_reg) && (freq_reg < fifth_reg));
                vco_next   = quotient;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg    <= freq_next;
        pattern_reg <= pattern_next;
        ratio_reg   <= ratio_next;
        swap_reg    <= swap_next;
        vco_reg     <= vco_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign filter_pattern = pattern_reg;
    assign prescale_ratio = ratio_reg;
    assign iq_swap        = swap_reg;
    assign vco_freq       = vco_reg;

    // A tune transaction occupies the block; a table write does not
    a_tune_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !cmd |=> busy)
        else $error("tune transaction did not start the sequencer");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd |=> !busy && !done)
        else $error("table write started the sequencer");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(state_reg == ST_FIN))
        else $error("result strobe outside the finish step");

    a_ratio_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (prescale_ratio == 7'd1) || (prescale_ratio == 7'd4) ||
                 (prescale_ratio == 7'd16) || (prescale_ratio == 7'd64))
        else $error("illegal prescaler ratio");

endmodule
